// ----- hw/rtl/dsv_pkg.sv -----
// Package for the date string validator: character codes, the field state
// encoding and the calendar helper functions.
// No dependencies.
`timescale 1ns / 1ps

package dsv_pkg;

	localparam logic [7:0] CH_TERM  = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int MONTH_W = 7;
	localparam int DAY_W   = 7;
	localparam int YEAR_W  = 14;
	localparam int CNT_W   = 3;

	localparam logic [CNT_W-1:0] MD_DIGITS   = 3'd2;
	localparam logic [CNT_W-1:0] YEAR_DIGITS = 3'd4;
	localparam logic [MONTH_W-1:0] MONTHS    = 7'd12;

	// Field currently being parsed.
	typedef enum logic [2:0] {
		PH_MONTH = 3'b001,
		PH_DAY   = 3'b010,
		PH_YEAR  = 3'b100
	} phase_t;

	// A two-digit BCD number is a multiple of four when the tens digit is
	// even and the ones digit is 0, 4 or 8, or the tens digit is odd and the
	// ones digit is 2 or 6.
	function automatic logic bcd_div4(input logic [3:0] tens, input logic [3:0] ones);
		logic r;
		if (tens[0] == 1'b0) begin
			r = ones inside {4'd0, 4'd4, 4'd8};
		end else begin
			r = ones inside {4'd2, 4'd6};
		end
		return r;
	endfunction

	// Gregorian leap rule on the four year digits, most significant first.
	function automatic logic bcd_leap(input logic [3:0][3:0] yd);
		logic r;
		if (yd[1] == 4'd0 && yd[0] == 4'd0) begin
			r = bcd_div4(yd[3], yd[2]);
		end else begin
			r = bcd_div4(yd[1], yd[0]);
		end
		return r;
	endfunction

	// Days in a month; months up to July alternate 31/30 starting with 31,
	// from August on the pattern shifts by one.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [MONTH_W-1:0] adj;
		logic [DAY_W-1:0] r;
		adj = (m > 7'd7) ? m - 7'd1 : m;
		if (m == 7'd2) begin
			r = leap ? 7'd29 : 7'd28;
		end else begin
			r = adj[0] ? 7'd31 : 7'd30;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/dsv_if.sv -----
// Channel interfaces of the date string validator: the character stream in
// and the parsed date out. Depends on dsv_pkg.
`timescale 1ns / 1ps

interface dsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface dsv_date_if import dsv_pkg::*;;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic [MONTH_W-1:0] month_value;
	logic [DAY_W-1:0]   day_value;
	logic [YEAR_W-1:0]  year_value;

	modport source (output valid, output valid_res, output month_value,
		output day_value, output year_value, input ready);
	modport sink (input valid, input valid_res, input month_value,
		input day_value, input year_value, output ready);
endinterface

// ----- hw/rtl/date_string_validator_unit.sv -----
// Top level of the date string validator: parses M/D/YYYY strings one
// character per beat. Depends on dsv_pkg and the interfaces in dsv_if.
`timescale 1ns / 1ps

// Usage
// The chars channel carries one ASCII character per beat. A string has the
// form M/D/YYYY (month and day of one or two digits) and ends with a zero
// byte. Every other character produces no output. The terminator produces
// one beat on the dates channel: valid_res and the parsed month, day and
// year, all value fields zero when valid_res is low.
// A character is captured in the input register and then parsed into the field
// state registers; a terminator's result is written to the output register.
// Throughput: one character per cycle while no terminator waits on a full
// result slot, as the field state registers update from the input register.
// When the receiver stalls, a finished result waits in the output register
// while characters keep flowing; only a second terminator reaching the input
// register holds there until the waiting result is taken.
// Reset clears the field state, the sticky error and both valid flags, so the
// block starts in the month field of a fresh string.
module date_string_validator_unit import dsv_pkg::*; (
	input logic clk,
	input logic arst_n,
	dsv_char_if.sink chars,
	dsv_date_if.source dates
);

	logic               vld_s1;
	logic [7:0]         ch_s1;

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [MONTH_W-1:0] month_q, month_d;
	logic [DAY_W-1:0]   day_q, day_d;
	logic [YEAR_W-1:0]  year_q, year_d;
	logic [3:0][3:0]    ybcd_q, ybcd_d;
	logic               bad_q, bad_d;

	logic               out_vld_q;
	logic               res_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [DAY_W-1:0]   res_day_q;
	logic [YEAR_W-1:0]  res_year_q;

	logic               is_term, is_digit, is_slash;
	logic               s1_go;
	logic [3:0]         digit;
	logic               ok;

	assign is_term  = (ch_s1 == CH_TERM);
	assign is_slash = (ch_s1 == CH_SLASH);
	assign is_digit = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign digit    = 4'(ch_s1 - CH_ZERO);

	// A terminator can only leave the input register when the result slot is
	// free or being emptied in the same cycle.
	assign s1_go = vld_s1 && !(is_term && out_vld_q && !dates.ready);
	assign chars.ready = !vld_s1 || s1_go;

	assign ok = !bad_q && (phase_q == PH_YEAR) && (cnt_q == YEAR_DIGITS)
		&& (month_q != '0) && (month_q <= MONTHS)
		&& (day_q != '0) && (day_q <= month_len(month_q, bcd_leap(ybcd_q)));

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		month_d = month_q;
		day_d   = day_q;
		year_d  = year_q;
		ybcd_d  = ybcd_q;
		bad_d   = bad_q;
		if (is_term) begin
			phase_d = PH_MONTH;
			cnt_d   = '0;
			month_d = '0;
			day_d   = '0;
			year_d  = '0;
			bad_d   = 1'b0;
		end else if (!bad_q) begin
			if (is_digit) begin
				case (phase_q)
					PH_MONTH: begin
						if (cnt_q < MD_DIGITS) begin
							month_d = 7'({month_q, 3'b000} + {month_q, 1'b0} + MONTH_W'(digit));
							cnt_d   = cnt_q + 3'd1;
						end else begin
							bad_d = 1'b1;
						end
					end
					PH_DAY: begin
						if (cnt_q < MD_DIGITS) begin
							day_d = 7'({day_q, 3'b000} + {day_q, 1'b0} + DAY_W'(digit));
							cnt_d = cnt_q + 3'd1;
						end else begin
							bad_d = 1'b1;
						end
					end
					PH_YEAR: begin
						if (cnt_q < YEAR_DIGITS) begin
							year_d = 14'({year_q, 3'b000} + {year_q, 1'b0} + YEAR_W'(digit));
							ybcd_d = {ybcd_q[2:0], digit};
							cnt_d  = cnt_q + 3'd1;
						end else begin
							bad_d = 1'b1;
						end
					end
					default: bad_d = 1'b1;
				endcase
			end else if (is_slash) begin
				case (phase_q)
					PH_MONTH: begin
						if (cnt_q != '0) begin
							phase_d = PH_DAY;
							cnt_d   = '0;
						end else begin
							bad_d = 1'b1;
						end
					end
					PH_DAY: begin
						if (cnt_q != '0) begin
							phase_d = PH_YEAR;
							cnt_d   = '0;
						end else begin
							bad_d = 1'b1;
						end
					end
					default: bad_d = 1'b1;
				endcase
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready) begin
			ch_s1 <= chars.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MONTH;
			cnt_q   <= '0;
			month_q <= '0;
			day_q   <= '0;
			year_q  <= '0;
			bad_q   <= 1'b0;
		end else if (s1_go) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			month_q <= month_d;
			day_q   <= day_d;
			year_q  <= year_d;
			bad_q   <= bad_d;
		end
	end

	// The BCD copy of the year is only read once four digits have been
	// shifted in since the last terminator, so it needs no reset.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			ybcd_q <= ybcd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && is_term) begin
			out_vld_q <= 1'b1;
		end else if (dates.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_term) begin
			res_q       <= ok;
			res_month_q <= ok ? month_q : '0;
			res_day_q   <= ok ? day_q : '0;
			res_year_q  <= ok ? year_q : '0;
		end
	end

	assign dates.valid       = out_vld_q;
	assign dates.valid_res   = res_q;
	assign dates.month_value = res_month_q;
	assign dates.day_value   = res_day_q;
	assign dates.year_value  = res_year_q;

`ifndef SYNTH
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q |-> res_month_q != '0 && res_month_q <= MONTHS)
		else $error("valid result with month out of range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !res_q |-> res_month_q == '0 && res_day_q == '0
		&& res_year_q == '0)
		else $error("invalid result carries nonzero fields");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_YEAR |-> cnt_q <= MD_DIGITS) and (cnt_q <= YEAR_DIGITS))
		else $error("digit count beyond field width");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && is_term |=> phase_q == PH_MONTH && cnt_q == '0 && !bad_q
		&& out_vld_q)
		else $error("terminator did not clear state or post a result");

	a_term_waits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && is_term && out_vld_q && !dates.ready |=> vld_s1 && $stable(ch_s1))
		else $error("terminator dropped while result slot was full");
`endif

endmodule

// ----- sim/date_string_validator_unit_tb.sv -----
// Self-checking testbench for date_string_validator_unit: M/D/YYYY strings
// with random stalls on both channels, checked beat by beat against a predictor.
// Depends on dsv_pkg, the channel interfaces in dsv_if and the RTL top level.
`timescale 1ns / 1ps

module date_string_validator_unit_tb;
	import dsv_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] char_q_t[$];

	typedef struct packed {
		logic               valid_res;
		logic [MONTH_W-1:0] month_value;
		logic [DAY_W-1:0]   day_value;
		logic [YEAR_W-1:0]  year_value;
	} date_t;

	logic clk = 1'b0;
	logic arst_n;

	dsv_char_if chars ();
	dsv_date_if dates ();

	date_string_validator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.dates(dates)
	);

	always #1 clk = ~clk;

	// Characters waiting to be driven and dates the predictor has produced.
	logic [7:0] pending_chars[$];
	date_t expected_dates[$];

	// Predictor copy of the parser state.
	phase_t             acc_phase = PH_MONTH;
	logic [CNT_W-1:0]   acc_digits = '0;
	logic [MONTH_W-1:0] acc_month = '0;
	logic [DAY_W-1:0]   acc_day = '0;
	logic [YEAR_W-1:0]  acc_year = '0;
	logic               acc_bad = 1'b0;

	int chars_queued = 0;
	int chars_sent = 0;
	int dates_valid = 0;
	int dates_rejected = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	logic char_taken = 1'b0;

	function automatic int month_days(input int m, input int y);
		logic leap;
		leap = (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
		if (m == 2) begin
			return leap ? 29 : 28;
		end
		if (m == 4 || m == 6 || m == 9 || m == 11) begin
			return 30;
		end
		return 31;
	endfunction

	// Advance the predictor by one accepted character.
	task automatic parse_char(input logic [7:0] c);
		date_t want;
		logic [3:0] d;
		logic ok;
		if (c == CH_TERM) begin
			ok = !acc_bad && acc_phase == PH_YEAR && acc_digits == YEAR_DIGITS
				&& acc_month >= 1 && acc_month <= MONTHS && acc_day >= 1
				&& acc_day <= month_days(acc_month, acc_year);
			want.valid_res = ok;
			want.month_value = ok ? acc_month : '0;
			want.day_value = ok ? acc_day : '0;
			want.year_value = ok ? acc_year : '0;
			expected_dates.push_back(want);
			acc_phase = PH_MONTH;
			acc_digits = '0;
			acc_month = '0;
			acc_day = '0;
			acc_year = '0;
			acc_bad = 1'b0;
		end else if (!acc_bad) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = 4'(c - CH_ZERO);
				if (acc_phase == PH_MONTH && acc_digits < MD_DIGITS) begin
					acc_month = MONTH_W'(acc_month * 10 + d);
					acc_digits = acc_digits + 3'd1;
				end else if (acc_phase == PH_DAY && acc_digits < MD_DIGITS) begin
					acc_day = DAY_W'(acc_day * 10 + d);
					acc_digits = acc_digits + 3'd1;
				end else if (acc_phase == PH_YEAR && acc_digits < YEAR_DIGITS) begin
					acc_year = YEAR_W'(acc_year * 10 + d);
					acc_digits = acc_digits + 3'd1;
				end else begin
					acc_bad = 1'b1;
				end
			end else if (c == CH_SLASH) begin
				if (acc_phase != PH_YEAR && acc_digits != 0) begin
					acc_phase = (acc_phase == PH_MONTH) ? PH_DAY : PH_YEAR;
					acc_digits = '0;
				end else begin
					acc_bad = 1'b1;
				end
			end else begin
				acc_bad = 1'b1;
			end
		end
	endtask

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t ERROR %s", $time, msg);
		end
	endtask

	// Append a string and its terminator to the stimulus.
	task automatic queue_chars(input char_q_t s);
		foreach (s[i]) begin
			pending_chars.push_back(s[i]);
		end
		pending_chars.push_back(CH_TERM);
		chars_queued += s.size() + 1;
	endtask

	task automatic queue_text(input string t);
		char_q_t s;
		for (int i = 0; i < t.len(); i++) begin
			s.push_back(t[i]);
		end
		queue_chars(s);
	endtask

	task automatic push_digits(ref char_q_t s, input int value, input int width);
		for (int i = width - 1; i >= 0; i--) begin
			s.push_back(8'(CH_ZERO + (value / (10 ** i)) % 10));
		end
	endtask

	// Mostly well-formed dates near the calendar edges, some broken by one
	// edit, and a little pure noise.
	task automatic queue_random_string();
		char_q_t s;
		int kind, r, m, d, y, lim, pos;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(12)) begin
				s.push_back(8'($urandom_range(255, 1)));
			end
		end else begin
			r = $urandom_range(9);
			if (r < 2) begin
				m = 2;
			end else if (r < 8) begin
				m = $urandom_range(12, 1);
			end else if (r == 8) begin
				m = $urandom_range(1) ? 0 : 13;
			end else begin
				m = $urandom_range(99);
			end
			case ($urandom_range(3))
				0: begin
					y = $urandom_range(99) * 100;
				end
				1: begin
					y = $urandom_range(2499) * 4;
				end
				default: begin
					y = $urandom_range(9999);
				end
			endcase
			lim = (m >= 1 && m <= 12) ? month_days(m, y) : 31;
			r = $urandom_range(9);
			if (r < 6) begin
				d = $urandom_range(lim, 1);
			end else if (r < 8) begin
				d = lim + $urandom_range(1);
			end else if (r == 8) begin
				d = 0;
			end else begin
				d = $urandom_range(99);
			end
			push_digits(s, m, (m < 10 && $urandom_range(1)) ? 1 : 2);
			s.push_back(CH_SLASH);
			push_digits(s, d, (d < 10 && $urandom_range(1)) ? 1 : 2);
			s.push_back(CH_SLASH);
			push_digits(s, y, 4);
			if (kind >= 78) begin
				pos = $urandom_range(s.size() - 1);
				case ($urandom_range(4))
					0: begin
						s.insert(pos, 8'($urandom_range(255, 1)));
					end
					1: begin
						s.delete(pos);
					end
					2: begin
						// The terminator arrives early.
						while (s.size() > pos) begin
							void'(s.pop_back());
						end
					end
					3: begin
						s.insert(pos, 8'(CH_ZERO + $urandom_range(9)));
					end
					default: begin
						s.insert(pos, CH_SLASH);
					end
				endcase
			end
		end
		queue_chars(s);
	endtask

	// Checked at the falling edge, where the monitor's updates have settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (!(chars_sent == chars_queued && expected_dates.size() == 0));
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!chars.valid || char_taken) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					chars.valid <= 1'b1;
					chars.ch <= pending_chars.pop_front();
				end else begin
					chars.valid <= 1'b0;
					chars.ch <= 8'($urandom);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				dates.ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done <= holds_done + 1;
				hold_left <= HOLD_CYCLES;
				dates.ready <= 1'b0;
			end else begin
				dates.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		date_t want, got;
		if (arst_n) begin
			char_taken <= chars.valid && chars.ready;
			if (chars.valid && chars.ready) begin
				parse_char(chars.ch);
				chars_sent++;
			end
			if (dates.valid && dates.ready) begin
				got.valid_res = dates.valid_res;
				got.month_value = dates.month_value;
				got.day_value = dates.day_value;
				got.year_value = dates.year_value;
				if (got.valid_res === 1'b1) begin
					dates_valid++;
				end else begin
					dates_rejected++;
				end
				if (expected_dates.size() == 0) begin
					flag_error($sformatf("unexpected date beat: ok=%b %0d/%0d/%0d",
						got.valid_res, got.month_value, got.day_value, got.year_value));
				end else begin
					want = expected_dates.pop_front();
					if (got.valid_res !== want.valid_res
							|| got.month_value !== want.month_value
							|| got.day_value !== want.day_value
							|| got.year_value !== want.year_value) begin
						flag_error($sformatf(
							"date mismatch: expected ok=%b %0d/%0d/%0d, got ok=%b %0d/%0d/%0d",
							want.valid_res, want.month_value, want.day_value,
							want.year_value, got.valid_res, got.month_value,
							got.day_value, got.year_value));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars.valid && chars.ready) || (dates.valid && dates.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat on either channel for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.ch = 8'h00;
		dates.ready = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 67;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest fields, a century year that is not a leap year, a high byte
		// and an empty string.
		queue_text("12/31/9999");
		queue_text("2/29/1900");
		queue_text("\377");
		queue_text("");
		while (chars_queued < 450) begin
			queue_random_string();
		end
		wait_drained();

		@(posedge clk);
		send_idle_pct = 67;
		recv_idle_pct = 33;
		while (chars_queued < 880) begin
			queue_random_string();
		end
		wait_drained();

		// No idling, but the receiver stops for a long stretch at the start so
		// the result register fills and the character input backs up.
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		while (chars_queued < 1300) begin
			queue_random_string();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("checked %0d date beats (%0d valid, %0d rejected) from %0d characters",
			dates_valid + dates_rejected, dates_valid, dates_rejected, chars_sent);
		$display("three stall mixes, one long receiver hold-off, %0d mismatches",
			error_count);
		if (error_count == 0 && expected_dates.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
